// ----- hdl/d2e_pkg.sv -----
// Shared types and constants of the dense to ELLPACK converter.
package d2e_pkg;

    localparam int VAL_W  = 32;   // element and entry value width
    localparam int IDX_W  = 3;    // column, row and slot index port width
    localparam int DEG_W  = 4;    // degree port width
    localparam int CFG_W  = 4;    // row_count / col_count register width
    localparam int APB_DW = 32;   // APB data width

    localparam logic [CFG_W-1:0] CFG_DIM_RESET = 4'd8;

    // register select, taken from paddr[2]
    typedef enum logic {
        REG_ROW_COUNT = 1'b0,
        REG_COL_COUNT = 1'b1
    } t_reg_sel;

    // controller -> datapath
    typedef struct packed {
        logic load;        // element request taken this cycle
        logic count;       // count one row
        logic emit_rd;     // select next entry, read store
        logic emit_load;   // move entry into output register
    } t_d2e_cmd;

    // datapath -> controller
    typedef struct packed {
        logic load_last;   // current load position is the final element
        logic count_last;  // counting the final row
        logic deg_zero;    // degree would be zero after this count step
        logic emit_last;   // entry in the read stage is the final one
        logic out_free;    // output register can take an entry
    } t_d2e_sts;

endpackage

// ----- hdl/d2e_ctrl.sv -----
// Sequencing state machine of the dense to ELLPACK converter.
module d2e_ctrl
    import d2e_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  t_d2e_sts i_sts,
    output logic     o_in_ready,
    output t_d2e_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_LOAD,
        S_COUNT,
        S_EMIT_RD,
        S_EMIT_LOAD
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_in_ready = (r_state == S_LOAD);

    always_comb begin
        o_cmd           = '0;
        o_cmd.load      = (r_state == S_LOAD) && i_in_valid;
        o_cmd.count     = (r_state == S_COUNT);
        o_cmd.emit_rd   = (r_state == S_EMIT_RD);
        o_cmd.emit_load = (r_state == S_EMIT_LOAD) && i_sts.out_free;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_LOAD: begin
                if (i_in_valid && i_sts.load_last) n_state = S_COUNT;
            end
            S_COUNT: begin
                if (i_sts.count_last) n_state = i_sts.deg_zero ? S_LOAD : S_EMIT_RD;
            end
            S_EMIT_RD: begin
                n_state = S_EMIT_LOAD;
            end
            S_EMIT_LOAD: begin
                if (i_sts.out_free) n_state = i_sts.emit_last ? S_LOAD : S_EMIT_RD;
            end
            default: n_state = S_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    a_emit_follows_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT_LOAD) |->
            ($past(r_state) == S_EMIT_RD) || ($past(r_state) == S_EMIT_LOAD))
        else $error("output load stage entered without a store read");

    a_count_to_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COUNT && i_sts.count_last && !i_sts.deg_zero) |=>
            (r_state == S_EMIT_RD))
        else $error("nonzero matrix did not start emission");

endmodule

// ----- hdl/d2e_datapath.sv -----
// Matrix store, row masks, degree count and entry emission of the converter.
module d2e_datapath
    import d2e_pkg::*;
#(
    parameter int MAX_ROWS = 8,
    parameter int MAX_COLS = 8,
    localparam int RW = ($clog2(MAX_ROWS) > 0) ? $clog2(MAX_ROWS) : 1,
    localparam int CW = ($clog2(MAX_COLS) > 0) ? $clog2(MAX_COLS) : 1
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_d2e_cmd                 i_cmd,
    output t_d2e_sts                 o_sts,
    input  logic [RW-1:0]            i_row_last,
    input  logic [CW-1:0]            i_col_last,
    input  logic                     i_cfg_clear,
    input  logic signed [VAL_W-1:0]  i_element_value,
    input  logic                     i_out_ready,
    output logic                     o_out_valid,
    output logic signed [VAL_W-1:0]  o_entry_value,
    output logic [IDX_W-1:0]         o_column_index,
    output logic [IDX_W-1:0]         o_row_index,
    output logic [IDX_W-1:0]         o_slot_index,
    output logic [DEG_W-1:0]         o_max_degree,
    output logic                     o_last_result
);

    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = ($clog2(DEPTH) > 0) ? $clog2(DEPTH) : 1;
    localparam int DW    = $clog2(MAX_COLS + 1);
    localparam int PW    = CW + RW + 1;

    function automatic logic [DW-1:0] f_popcount(input logic [MAX_COLS-1:0] m);
        logic [DW-1:0] s;
        s = '0;
        for (int c = 0; c < MAX_COLS; c++) s = s + DW'(m[c]);
        return s;
    endfunction

    function automatic logic [CW-1:0] f_lowest(input logic [MAX_COLS-1:0] m);
        logic [CW-1:0] p;
        p = '0;
        for (int c = MAX_COLS - 1; c >= 0; c--) if (m[c]) p = CW'(c);
        return p;
    endfunction

    // store and its registered read port
    logic [VAL_W-1:0]    r_mem [DEPTH];
    logic [VAL_W-1:0]    r_rd_data;

    // load position
    logic [AW-1:0]       r_load_cnt;
    logic [RW-1:0]       r_load_row;
    logic [CW-1:0]       r_load_col;

    // nonzero masks per row, and the copy peeled during emission
    logic [MAX_COLS-1:0] r_row_mask [MAX_ROWS];
    logic [MAX_COLS-1:0] r_rem      [MAX_ROWS];

    logic [RW-1:0]       r_cnt_row;
    logic [DW-1:0]       r_deg;
    logic [RW-1:0]       r_em_row;
    logic [CW-1:0]       r_em_slot;

    // read stage
    logic                r_p_have;
    logic [CW-1:0]       r_p_col;
    logic [RW-1:0]       r_p_row;
    logic [CW-1:0]       r_p_slot;
    logic                r_p_last;

    // output register
    logic                r_out_valid;
    logic [VAL_W-1:0]    r_out_value;
    logic [IDX_W-1:0]    r_out_col;
    logic [IDX_W-1:0]    r_out_row;
    logic [IDX_W-1:0]    r_out_slot;
    logic [DEG_W-1:0]    r_out_deg;
    logic                r_out_last;

    logic                load_last;
    logic [DW-1:0]       cnt_pop;
    logic [DW-1:0]       deg_max;
    logic [MAX_COLS-1:0] em_mask;
    logic                em_have;
    logic [CW-1:0]       em_col;
    logic [PW-1:0]       em_addr_full;
    logic                em_last;
    logic                elem_nz;

    assign elem_nz   = (i_element_value != '0);
    assign load_last = (r_load_row == i_row_last) && (r_load_col == i_col_last);
    assign cnt_pop   = f_popcount(r_row_mask[r_cnt_row]);
    assign deg_max   = (cnt_pop > r_deg) ? cnt_pop : r_deg;
    assign em_mask   = r_rem[r_em_row];
    assign em_have   = (em_mask != '0);
    assign em_col    = f_lowest(em_mask);
    assign em_addr_full = PW'(em_col) * (PW'(i_row_last) + PW'(1)) + PW'(r_em_row);
    assign em_last   = ((DW'(r_em_slot) + DW'(1)) == r_deg) && (r_em_row == i_row_last);

    always_comb begin
        o_sts            = '0;
        o_sts.load_last  = load_last;
        o_sts.count_last = (r_cnt_row == i_row_last);
        o_sts.deg_zero   = (deg_max == '0);
        o_sts.emit_last  = r_p_last;
        o_sts.out_free   = !r_out_valid || i_out_ready;
    end

    // store write and read
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_mem[r_load_cnt] <= i_element_value;
        if (i_cmd.emit_rd) r_rd_data <= r_mem[em_addr_full[AW-1:0]];
    end

    // load position, column-major
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_clear) begin
            r_load_cnt <= '0;
            r_load_row <= '0;
            r_load_col <= '0;
        end else if (i_cmd.load) begin
            if (load_last) begin
                r_load_cnt <= '0;
                r_load_row <= '0;
                r_load_col <= '0;
            end else begin
                r_load_cnt <= r_load_cnt + AW'(1);
                if (r_load_row == i_row_last) begin
                    r_load_row <= '0;
                    r_load_col <= r_load_col + CW'(1);
                end else begin
                    r_load_row <= r_load_row + RW'(1);
                end
            end
        end
    end

    // mask bits; column 0 of a row clears the stale columns of the last matrix
    always_ff @(posedge i_clk) begin
        for (int r = 0; r < MAX_ROWS; r++) begin
            for (int c = 0; c < MAX_COLS; c++) begin
                if (i_cmd.load && (r_load_row == RW'(r))) begin
                    if (r_load_col == CW'(c)) r_row_mask[r][c] <= elem_nz;
                    else if (r_load_col == '0) r_row_mask[r][c] <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.count) r_rem[r_cnt_row] <= r_row_mask[r_cnt_row];
        else if (i_cmd.emit_rd) r_rem[r_em_row] <= em_mask & (em_mask - MAX_COLS'(1));
    end

    // counting pass and emission indices
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_row <= '0;
            r_deg     <= '0;
            r_em_row  <= '0;
            r_em_slot <= '0;
            r_p_last  <= 1'b0;
        end else begin
            if (i_cmd.load && load_last) begin
                r_cnt_row <= '0;
                r_deg     <= '0;
            end else if (i_cmd.count) begin
                r_deg     <= deg_max;
                r_cnt_row <= (r_cnt_row == i_row_last) ? '0 : r_cnt_row + RW'(1);
                r_em_row  <= '0;
                r_em_slot <= '0;
            end else if (i_cmd.emit_rd) begin
                r_p_last <= em_last;
                if (r_em_row == i_row_last) begin
                    r_em_row  <= '0;
                    r_em_slot <= r_em_slot + CW'(1);
                end else begin
                    r_em_row <= r_em_row + RW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_rd) begin
            r_p_have <= em_have;
            r_p_col  <= em_have ? em_col : '0;
            r_p_row  <= r_em_row;
            r_p_slot <= r_em_slot;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_load) begin
            r_out_value <= r_p_have ? r_rd_data : '0;
            r_out_col   <= IDX_W'(r_p_col);
            r_out_row   <= IDX_W'(r_p_row);
            r_out_slot  <= IDX_W'(r_p_slot);
            r_out_deg   <= DEG_W'(r_deg);
            r_out_last  <= r_p_last;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_entry_value  = r_out_value;
    assign o_column_index = r_out_col;
    assign o_row_index    = r_out_row;
    assign o_slot_index   = r_out_slot;
    assign o_max_degree   = r_out_deg;
    assign o_last_result  = r_out_last;

    a_pad_column_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_value == '0) |-> (r_out_col == '0))
        else $error("padding entry with nonzero column");

    a_slot_below_degree: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_deg != '0) && (DEG_W'(r_out_slot) < r_out_deg))
        else $error("slot index not below degree");

    a_degree_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.count |=> (r_deg >= $past(r_deg)))
        else $error("degree shrank during counting pass");

endmodule

// ----- hdl/dense_to_ellpack_converter.sv -----
// Top level of the dense to ELLPACK converter: config registers and block wiring.
//
// Dense to ELLPACK converter. Load a row_count x col_count matrix of signed
// Q16.16 elements in column-major order, one element request per cycle. After
// the last element the block counts each row's nonzeros (one row per cycle),
// then emits the ELLPACK form in slot-major order, slot k then row i: each
// result is row i's k-th nonzero value and its column, or value 0 / column 0
// as padding, and carries the degree and a last flag on the final result.
// An all-zero matrix gives no results. Per matrix: rows*cols elements
// loaded, each row counted, then rows*degree results, each taking one
// controller state for the store read and one for the output register
// load, which sets the emission rate; output stalls hold the output load
// state. While counting and emitting, o_in_ready is low; the final result
// may still wait in the output register while loading of the next matrix
// goes on.
// row_count (byte address 0) and col_count (byte address 4) are 4-bit
// registers, reset 8; 0 acts as 1 and values above the maximum act as the
// maximum. Any register write restarts the load in progress. Write only
// while no results are outstanding. pready is tied high.
module dense_to_ellpack_converter
    import d2e_pkg::*;
#(
    parameter int MAX_ROWS = 8,
    parameter int MAX_COLS = 8
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // config port
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [2:0]              paddr,
    input  logic [APB_DW-1:0]       pwdata,
    output logic [APB_DW-1:0]       prdata,
    output logic                    pready,
    // element requests
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic signed [VAL_W-1:0] i_element_value,
    // result requests
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic signed [VAL_W-1:0] o_entry_value,
    output logic [IDX_W-1:0]        o_column_index,
    output logic [IDX_W-1:0]        o_row_index,
    output logic [IDX_W-1:0]        o_slot_index,
    output logic [DEG_W-1:0]        o_max_degree,
    output logic                    o_last_result
);

    localparam int RW = ($clog2(MAX_ROWS) > 0) ? $clog2(MAX_ROWS) : 1;
    localparam int CW = ($clog2(MAX_COLS) > 0) ? $clog2(MAX_COLS) : 1;

    logic [CFG_W-1:0] r_row_count;
    logic [CFG_W-1:0] r_col_count;
    logic             cfg_wr;
    t_reg_sel         reg_sel;
    logic [RW-1:0]    row_last;
    logic [CW-1:0]    col_last;
    t_d2e_cmd         cmd;
    t_d2e_sts         sts;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_sel = t_reg_sel'(paddr[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count <= CFG_DIM_RESET;
            r_col_count <= CFG_DIM_RESET;
        end else if (cfg_wr) begin
            unique case (reg_sel)
                REG_ROW_COUNT: r_row_count <= pwdata[CFG_W-1:0];
                REG_COL_COUNT: r_col_count <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_ROW_COUNT: prdata = APB_DW'(r_row_count);
            REG_COL_COUNT: prdata = APB_DW'(r_col_count);
            default:       prdata = '0;
        endcase
    end

    // clamp to 1..MAX, carried as last index
    always_comb begin
        if (r_row_count == '0) row_last = '0;
        else if (32'(r_row_count) > MAX_ROWS) row_last = RW'(MAX_ROWS - 1);
        else row_last = RW'(r_row_count - CFG_W'(1));

        if (r_col_count == '0) col_last = '0;
        else if (32'(r_col_count) > MAX_COLS) col_last = CW'(MAX_COLS - 1);
        else col_last = CW'(r_col_count - CFG_W'(1));
    end

    d2e_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    d2e_datapath #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_row_last      (row_last),
        .i_col_last      (col_last),
        .i_cfg_clear     (cfg_wr),
        .i_element_value (i_element_value),
        .i_out_ready     (i_out_ready),
        .o_out_valid     (o_out_valid),
        .o_entry_value   (o_entry_value),
        .o_column_index  (o_column_index),
        .o_row_index     (o_row_index),
        .o_slot_index    (o_slot_index),
        .o_max_degree    (o_max_degree),
        .o_last_result   (o_last_result)
    );

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for the dense to ELLPACK converter.
`timescale 1ns / 100ps

module tb_top;
    import d2e_pkg::*;

    localparam int MAX_ROWS     = 8;
    localparam int MAX_COLS     = 8;
    localparam int SETTLE_CYCLES = 24;      // covers the row counting pass of an all-zero matrix
    localparam int CYCLE_LIMIT   = 200000;
    localparam int RANDOM_ITEMS  = 120;
    localparam int LONG_HOLD     = 300;     // receiver back-pressure stretch, in cycles

    // one ELLPACK entry as it leaves the block
    typedef struct {
        logic [VAL_W-1:0] value;
        logic [IDX_W-1:0] column;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] slot;
        logic [DEG_W-1:0] degree;
        logic             is_last;
    } t_ell_entry;

    // clock and reset
    logic i_clk = 1'b0;
    logic i_rst_n;
    always #5 i_clk = ~i_clk;

    // config port
    logic              psel, penable, pwrite, pready;
    logic [2:0]        paddr;
    logic [APB_DW-1:0] pwdata, prdata;

    // element and entry requests
    logic              in_valid, in_ready;
    logic [VAL_W-1:0]  element_value;
    logic              out_valid, rx_ready;
    logic [VAL_W-1:0]  entry_value;
    logic [IDX_W-1:0]  column_index, row_index, slot_index;
    logic [DEG_W-1:0]  max_degree;
    logic              last_result;

    dense_to_ellpack_converter #(
        .MAX_ROWS(MAX_ROWS),
        .MAX_COLS(MAX_COLS)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_element_value(element_value),
        .o_out_valid    (out_valid),
        .i_out_ready    (rx_ready),
        .o_entry_value  (entry_value),
        .o_column_index (column_index),
        .o_row_index    (row_index),
        .o_slot_index   (slot_index),
        .o_max_degree   (max_degree),
        .o_last_result  (last_result)
    );

    // ------------------------------------------------------------------
    // Shadow of the block: raw dimension registers, the dense store being
    // filled and the queue of ELLPACK entries still owed by the block.
    // ------------------------------------------------------------------
    logic [CFG_W-1:0] rows_reg = CFG_DIM_RESET;
    logic [CFG_W-1:0] cols_reg = CFG_DIM_RESET;
    logic [VAL_W-1:0] dense_store [MAX_ROWS*MAX_COLS];
    int               fill_count = 0;
    t_ell_entry       pending_entries [$];

    int error_count  = 0;
    int cycle_count  = 0;
    bit tx_idle_on   = 1'b1;   // sender inserts random gaps
    bit rx_idle_on   = 1'b1;   // receiver inserts random stalls
    int hold_request = 0;      // long receiver stall, picked up by the receiver process

    // 0 acts as 1, anything above the maximum acts as the maximum
    function automatic int effective_dim(input logic [CFG_W-1:0] raw, input int maxv);
        if (raw == 0) return 1;
        if (raw > maxv) return maxv;
        return int'(raw);
    endfunction

    // Store one accepted element; on the final element of the matrix, count
    // nonzeros per row and queue the whole ELLPACK output in slot-major order.
    task automatic absorb_element(input logic [VAL_W-1:0] v);
        int               rows, cols, degree, i, j, k;
        int               nz_cnt [MAX_ROWS];
        int               nz_col [MAX_ROWS][MAX_COLS];
        logic [VAL_W-1:0] nz_val [MAX_ROWS][MAX_COLS];
        t_ell_entry       e;
        rows = effective_dim(rows_reg, MAX_ROWS);
        cols = effective_dim(cols_reg, MAX_COLS);
        if (fill_count >= rows * cols) fill_count = 0;
        dense_store[fill_count] = v;
        fill_count++;
        if (fill_count < rows * cols) return;
        fill_count = 0;

        degree = 0;
        for (i = 0; i < rows; i++) begin
            nz_cnt[i] = 0;
            for (j = 0; j < cols; j++) begin
                // column-major: element (i,j) sits at j*rows+i
                if (dense_store[j * rows + i] != '0) begin
                    nz_val[i][nz_cnt[i]] = dense_store[j * rows + i];
                    nz_col[i][nz_cnt[i]] = j;
                    nz_cnt[i]++;
                end
            end
            if (nz_cnt[i] > degree) degree = nz_cnt[i];
        end

        // an all-zero matrix owes nothing
        for (k = 0; k < degree; k++) begin
            for (i = 0; i < rows; i++) begin
                e.value   = (k < nz_cnt[i]) ? nz_val[i][k] : '0;
                e.column  = (k < nz_cnt[i]) ? IDX_W'(nz_col[i][k]) : '0;
                e.row     = IDX_W'(i);
                e.slot    = IDX_W'(k);
                e.degree  = DEG_W'(degree);
                e.is_last = (k == degree - 1) && (i == rows - 1);
                pending_entries.push_back(e);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Offer one element request and hold it until taken. Entered and left
    // just after a rising edge; valid is only lowered when a gap is drawn.
    task automatic send_element(input logic [VAL_W-1:0] v);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, 5) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid      <= 1'b1;
        element_value <= v;
        do @(posedge i_clk); while (!in_ready);
        absorb_element(v);
    endtask

    // Sender pause: drop valid, wait for every owed entry, then let the
    // counting pass of a possibly all-zero matrix finish.
    task automatic wait_for_idle();
        in_valid <= 1'b0;
        while (pending_entries.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write both dimension registers back to back (setup, access, setup,
    // access). Each write also restarts any load in progress.
    task automatic set_dims(input logic [CFG_W-1:0] rows, input logic [CFG_W-1:0] cols);
        wait_for_idle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_ROW_COUNT, 2'b00};
        pwdata  <= APB_DW'(rows);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rows_reg   = rows;
        fill_count = 0;
        penable <= 1'b0;
        paddr   <= {REG_COL_COUNT, 2'b00};
        pwdata  <= APB_DW'(cols);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        cols_reg   = cols;
        fill_count = 0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Element with a given chance of zero; the rest mixes extremes,
    // small Q16.16 magnitudes and full-range noise.
    function automatic logic [VAL_W-1:0] random_element(input int zero_pct);
        if ($urandom_range(0, 99) < zero_pct) return '0;
        case ($urandom_range(0, 5))
            0: begin
                case ($urandom_range(0, 3))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return 32'hFFFF_FFFF;
                    default: return 32'h0000_0001;
                endcase
            end
            1: return -$signed(VAL_W'($urandom_range(1, 32'h0003_FFFF)));
            2: return VAL_W'($urandom_range(1, 32'h0003_FFFF));
            default: return $urandom();
        endcase
    endfunction

    // mostly small sizes, sometimes the extremes or an out-of-range code
    function automatic logic [CFG_W-1:0] random_dim();
        case ($urandom_range(0, 9))
            0: return CFG_W'($urandom_range(0, 15));
            1: return CFG_W'(MAX_ROWS);
            2: return 4'd1;
            default: return CFG_W'($urandom_range(1, 4));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // 2x2: largest and smallest values, all ones, and row 0 padded in slot 1
    task automatic test_extreme_values();
        set_dims(4'd2, 4'd2);
        send_element(32'h7FFF_FFFF);
        send_element(32'h8000_0000);
        send_element(32'h0000_0000);
        send_element(32'hFFFF_FFFF);
    endtask

    // row code 0 acts as one row, column code 15 as eight columns: degree 8
    task automatic test_wide_row();
        int j;
        set_dims(4'd0, 4'd15);
        for (j = 0; j < MAX_COLS; j++) send_element(32'h0001_0000 * (j + 1) ^ 32'hA5A5_0000);
    endtask

    // row code 15 acts as eight rows, column code 0 as one column; sparse rows pad
    task automatic test_tall_column();
        set_dims(4'd15, 4'd0);
        send_element(32'h0000_0000);
        send_element(32'h0005_0000);
        send_element(32'h0000_0000);
        send_element(32'hFFFF_0000);
        send_element(32'h0000_0000);
        send_element(32'h0000_0000);
        send_element(32'h0000_0000);
        send_element(32'h0000_0001);
    endtask

    // a register write in the middle of a load throws away what was loaded
    task automatic test_restart_on_write();
        set_dims(4'd2, 4'd2);
        send_element(32'h1111_1111);
        send_element(32'h2222_2222);
        set_dims(4'd2, 4'd2);
        send_element(32'h0000_0000);
        send_element(32'h3333_3333);
        send_element(32'h4444_4444);
        send_element(32'h0000_0000);
    endtask

    // all-zero matrix owes nothing; the next one still converts
    task automatic test_all_zero();
        set_dims(4'd1, 4'd1);
        send_element(32'h0000_0000);
        wait_for_idle();
        send_element(32'h0001_0000);
    endtask

    // Receiver holds off for a long stretch while the sender keeps offering
    // a dense matrix and the next one: output register fills, input stalls.
    task automatic test_output_backpressure();
        int n;
        set_dims(4'd4, 4'd4);
        tx_idle_on   = 1'b0;
        hold_request = LONG_HOLD;
        for (n = 0; n < 32; n++) send_element(random_element(n < 16 ? 0 : 40));
        // sender pause with no register write, then one more matrix
        wait_for_idle();
        tx_idle_on = 1'b1;
        for (n = 0; n < 16; n++) send_element(random_element(20));
    endtask

    // Random sizes and sparsity, a few back-to-back matrices per setting,
    // and now and then a load broken off by a register write.
    task automatic test_random_matrices();
        int               sent, total, n, m, zero_pct;
        logic [CFG_W-1:0] rows, cols;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            rows  = random_dim();
            cols  = random_dim();
            total = effective_dim(rows, MAX_ROWS) * effective_dim(cols, MAX_COLS);
            set_dims(rows, cols);
            tx_idle_on = ($urandom_range(0, 3) != 0);
            rx_idle_on = ($urandom_range(0, 3) != 0);
            if (total > 1 && $urandom_range(0, 7) == 0) begin
                n = $urandom_range(1, total - 1);
                repeat (n) send_element(random_element(30));
                set_dims(rows, cols);
            end
            repeat ($urandom_range(1, 3)) begin
                case ($urandom_range(0, 3))
                    0: zero_pct = 0;
                    1: zero_pct = 30;
                    2: zero_pct = 60;
                    default: zero_pct = 90;
                endcase
                for (m = 0; m < total; m++) send_element(random_element(zero_pct));
                sent += total;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stall before each entry request, plus the long hold
    // that a test asks for, counted here.
    // ------------------------------------------------------------------
    initial begin : receiver
        int stall;
        rx_ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_request > 0) begin
                stall        = hold_request;
                hold_request = 0;
                rx_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            stall = rx_idle_on ? $urandom_range(0, 5) : 0;
            if (stall > 0) begin
                rx_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            rx_ready <= 1'b1;
            // leave on a taken entry, or early if a long hold is asked for
            @(posedge i_clk);
            while (!out_valid && hold_request == 0) @(posedge i_clk);
        end
    end

    // ------------------------------------------------------------------
    // Checker: every taken entry against the oldest owed one
    // ------------------------------------------------------------------
    task automatic check_field(input string label, input logic [VAL_W-1:0] want,
                               input logic [VAL_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, label, want, got);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin : result_checker
        t_ell_entry want;
        if (i_rst_n && out_valid && rx_ready) begin
            if (pending_entries.size() == 0) begin
                $display("%0t: unexpected entry, expected none, actual value %0h row %0d slot %0d",
                         $time, entry_value, row_index, slot_index);
                error_count++;
            end else begin
                want = pending_entries.pop_front();
                check_field("entry_value",  want.value, entry_value);
                check_field("column_index", VAL_W'(want.column), VAL_W'(column_index));
                check_field("row_index",    VAL_W'(want.row), VAL_W'(row_index));
                check_field("slot_index",   VAL_W'(want.slot), VAL_W'(slot_index));
                check_field("max_degree",   VAL_W'(want.degree), VAL_W'(max_degree));
                check_field("last_result",  VAL_W'(want.is_last), VAL_W'(last_result));
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n       <= 1'b0;
        in_valid      <= 1'b0;
        element_value <= '0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_extreme_values();
        test_wide_row();
        test_tall_column();
        test_restart_on_write();
        test_all_zero();
        test_output_backpressure();
        test_random_matrices();

        // drain what is owed, then watch a little longer for strays
        wait_for_idle();
        if (pending_entries.size() != 0) begin
            $display("%0t: %0d entries never arrived", $time, pending_entries.size());
            error_count++;
        end
        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
